[src/rri_pkg.sv]
// Shared constants, types and codes for the ray versus rectangle intersection block.
`timescale 1ns / 1ps

package rri_pkg;

    // Fixed point format of all t values and coordinates
    localparam int FRAC_BITS = 16;

    // Divider geometry: numerators are 33 bits, divisors 32 bits
    localparam int NUM_W   = 33;
    localparam int DEN_W   = 32;
    localparam int DVD_W   = NUM_W + FRAC_BITS;
    localparam int REM_W   = DEN_W + 2;
    localparam int DIV_LAT = DVD_W + 1;
    localparam int NDIV    = 4;

    localparam logic signed [31:0] T_MIN   = 32'sh8000_0000;
    localparam logic signed [31:0] T_MAX   = 32'sh7fff_ffff;
    localparam logic signed [31:0] NEG_ONE = -(32'sd1 << FRAC_BITS);

    // Configuration register indexes
    localparam logic [1:0] CFG_MIN_X = 2'd0;
    localparam logic [1:0] CFG_MIN_Y = 2'd1;
    localparam logic [1:0] CFG_MAX_X = 2'd2;
    localparam logic [1:0] CFG_MAX_Y = 2'd3;

    typedef enum logic [1:0] {
        MODE_PLANE,
        MODE_MISS,
        MODE_SLAB
    } mode_t;

    typedef struct packed {
        logic signed [31:0] min_x;
        logic signed [31:0] min_y;
        logic signed [31:0] max_x;
        logic signed [31:0] max_y;
    } rect_t;

    // Per-ray data that travels beside the dividers
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               x_zero;
        logic               y_zero;
        logic               x_in;
        logic               y_in;
    } side_t;

    // Classified word handed from the front to the back
    typedef struct packed {
        side_t                          side;
        logic [NDIV-1:0][NUM_W-1:0]     num;
        logic [NDIV-1:0][DEN_W-1:0]     den;
    } work_t;

endpackage

[src/ray_rectangle_intersect_top.sv]
// Top level of the ray versus axis-aligned rectangle intersection block.
//
//  channel | handshake                 | payload
//  --------+---------------------------+---------------------------------------------
//  in      | in_valid / in_stall       | origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
//  out     | out_valid / out_stall     | hit, t_enter, t_exit
//  cfg     | cfg_valid / cfg_ready     | cfg_index, cfg_data
//
//  One ray per cycle sustained while no stalled output word is held; the dividers
//  give one quotient bit per stage.
//  Reset clears all valid flags and loads the rectangle to [-0.5, 0.5] x [-0.5, 0.5].
//  A stall on out freezes the back pipeline; the two-word queue and the front register
//  keep taking rays until both are full.
`timescale 1ns / 1ps

module ray_rectangle_intersect_top import rri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] t_enter,
    output logic signed [31:0] t_exit,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    rect_t rect_reg;
    logic  q_full, q_empty, q_push, q_pop;
    work_t q_din, q_dout;

    assign cfg_ready = 1'b1;

    // Write the rectangle bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rect_reg.min_x <= -32'sd32768;
            rect_reg.min_y <= -32'sd32768;
            rect_reg.max_x <= 32'sd32768;
            rect_reg.max_y <= 32'sd32768;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_MIN_X: rect_reg.min_x <= $signed(cfg_data);
                CFG_MIN_Y: rect_reg.min_y <= $signed(cfg_data);
                CFG_MAX_X: rect_reg.max_x <= $signed(cfg_data);
                CFG_MAX_Y: rect_reg.max_y <= $signed(cfg_data);
                default:   rect_reg.min_x <= rect_reg.min_x;
            endcase
        end
    end

    rri_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .origin_x (origin_x),
        .origin_y (origin_y),
        .origin_z (origin_z),
        .dir_x    (dir_x),
        .dir_y    (dir_y),
        .dir_z    (dir_z),
        .rect     (rect_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_din    (q_din)
    );

    rri_queue u_queue
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_din),
        .pop   (q_pop),
        .dout  (q_dout),
        .full  (q_full),
        .empty (q_empty)
    );

    rri_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_dout    (q_dout),
        .q_pop     (q_pop),
        .rect      (rect_reg),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit),
        .t_enter   (t_enter),
        .t_exit    (t_exit)
    );

endmodule

[src/rri_front.sv]
// Front end: accepts rays, classifies them and forms the divider operands.
`timescale 1ns / 1ps

module rri_front import rri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic signed [31:0] origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [31:0] dir_z,
    input  rect_t              rect,
    input  logic               q_full,
    output logic               q_push,
    output work_t              q_din
);

    logic  vld_reg;
    work_t work_reg;
    work_t work_next;
    logic  take;

    logic signed [NUM_W-1:0] ox_w, oy_w, oz_w;
    logic signed [NUM_W-1:0] mnx_w, mxx_w, mny_w, mxy_w;

    // Hold the word while the queue is full
    assign in_stall = vld_reg && q_full;
    assign take     = in_valid && !in_stall;
    assign q_push   = vld_reg && !q_full;
    assign q_din    = work_reg;

    // Classify the ray and build the slab or plane operands
    always_comb
    begin
        ox_w  = NUM_W'(origin_x);
        oy_w  = NUM_W'(origin_y);
        oz_w  = NUM_W'(origin_z);
        mnx_w = NUM_W'(rect.min_x);
        mxx_w = NUM_W'(rect.max_x);
        mny_w = NUM_W'(rect.min_y);
        mxy_w = NUM_W'(rect.max_y);

        work_next.side.ox     = origin_x;
        work_next.side.oy     = origin_y;
        work_next.side.dx     = dir_x;
        work_next.side.dy     = dir_y;
        work_next.side.x_zero = (dir_x == 32'sd0);
        work_next.side.y_zero = (dir_y == 32'sd0);
        work_next.side.x_in   = (rect.min_x <= origin_x) && (origin_x <= rect.max_x);
        work_next.side.y_in   = (rect.min_y <= origin_y) && (origin_y <= rect.max_y);

        // Negative direction swaps which bound gives the entry
        if (dir_x[31])
        begin
            work_next.num[0] = mxx_w - ox_w;
            work_next.num[1] = mnx_w - ox_w;
        end
        else
        begin
            work_next.num[0] = mnx_w - ox_w;
            work_next.num[1] = mxx_w - ox_w;
        end
        if (dir_y[31])
        begin
            work_next.num[2] = mxy_w - oy_w;
            work_next.num[3] = mny_w - oy_w;
        end
        else
        begin
            work_next.num[2] = mny_w - oy_w;
            work_next.num[3] = mxy_w - oy_w;
        end
        // Keep the dividers fed with a nonzero divisor on axis-parallel rays
        work_next.den[0] = (dir_x == 32'sd0) ? 32'sd1 : dir_x;
        work_next.den[1] = (dir_x == 32'sd0) ? 32'sd1 : dir_x;
        work_next.den[2] = (dir_y == 32'sd0) ? 32'sd1 : dir_y;
        work_next.den[3] = (dir_y == 32'sd0) ? 32'sd1 : dir_y;

        if (dir_z != 32'sd0)
        begin
            work_next.side.mode = MODE_PLANE;
            work_next.num[0]    = -oz_w;
            work_next.den[0]    = dir_z;
        end
        else if (origin_z != 32'sd0)
        begin
            work_next.side.mode = MODE_MISS;
        end
        else
        begin
            work_next.side.mode = MODE_SLAB;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (take)
        begin
            vld_reg <= 1'b1;
        end
        else if (q_push)
        begin
            vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            work_reg <= work_next;
        end
    end

endmodule

[src/rri_queue.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps

module rri_queue import rri_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  work_t din,
    input  logic  pop,
    output work_t dout,
    output logic  full,
    output logic  empty
);

    work_t      mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);
    assign dout  = mem[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= din;
        end
    end

endmodule

[src/rri_div.sv]
// Pipelined restoring divider: one quotient bit per stage, saturated Q result.
`timescale 1ns / 1ps

module rri_div import rri_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic [NUM_W-1:0]   num,
    input  logic [DEN_W-1:0]   den,
    output logic signed [31:0] quo
);

    logic [REM_W-1:0] rem_reg  [DIV_LAT];
    logic [DVD_W-1:0] quo_reg  [DIV_LAT];
    logic [DEN_W:0]   dvs_reg  [DIV_LAT];
    logic             neg_reg  [DIV_LAT];
    logic [REM_W-1:0] rem_next [DIV_LAT];
    logic [DVD_W-1:0] quo_next [DIV_LAT];

    logic [NUM_W-1:0] num_mag;
    logic [DVD_W-1:0] q_mag;
    logic [REM_W-1:0] trial;

    // Load magnitudes, then shift in one dividend bit per stage
    always_comb
    begin
        num_mag     = num[NUM_W-1] ? (NUM_W'(0) - num) : num;
        rem_next[0] = '0;
        quo_next[0] = {num_mag, {FRAC_BITS{1'b0}}};
        for (int s = 1; s < DIV_LAT; s++)
        begin
            trial = {rem_reg[s-1][REM_W-2:0], quo_reg[s-1][DVD_W-1]};
            if (trial >= REM_W'(dvs_reg[s-1]))
            begin
                rem_next[s] = trial - REM_W'(dvs_reg[s-1]);
                quo_next[s] = {quo_reg[s-1][DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next[s] = trial;
                quo_next[s] = {quo_reg[s-1][DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dvs_reg[0] <= den[DEN_W-1] ? ((DEN_W+1)'(0) - {1'b1, den}) : {1'b0, den};
            neg_reg[0] <= num[NUM_W-1] ^ den[DEN_W-1];
            for (int s = 0; s < DIV_LAT; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
            for (int s = 1; s < DIV_LAT; s++)
            begin
                dvs_reg[s] <= dvs_reg[s-1];
                neg_reg[s] <= neg_reg[s-1];
            end
        end
    end

    // Apply the sign and saturate to 32 bits
    always_comb
    begin
        q_mag = quo_reg[DIV_LAT-1];
        if (q_mag[DVD_W-1:31] != '0)
        begin
            quo = neg_reg[DIV_LAT-1] ? T_MIN : T_MAX;
        end
        else if (neg_reg[DIV_LAT-1])
        begin
            quo = -$signed(q_mag[31:0]);
        end
        else
        begin
            quo = $signed(q_mag[31:0]);
        end
    end

endmodule

[src/rri_back.sv]
// Back end: divides, finds the plane point or combines slabs, registers results.
`timescale 1ns / 1ps

module rri_back import rri_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  work_t              q_dout,
    output logic               q_pop,
    input  rect_t              rect,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               hit,
    output logic signed [31:0] t_enter,
    output logic signed [31:0] t_exit
);

    logic en;

    logic               vld_reg  [DIV_LAT];
    side_t              side_reg [DIV_LAT];
    logic signed [31:0] div_q    [NDIV];

    logic               p_vld_reg;
    side_t              p_side_reg;
    logic signed [31:0] p_q_reg [NDIV];
    logic signed [63:0] prod_x_reg;
    logic signed [63:0] prod_y_reg;

    logic               out_valid_reg;
    logic               hit_reg;
    logic signed [31:0] t_enter_reg;
    logic signed [31:0] t_exit_reg;

    logic               hit_next;
    logic signed [31:0] te_next;
    logic signed [31:0] tx_next;
    logic signed [64:0] px, py;
    logic signed [31:0] lx, hx, ly, hy;

    // Whole back pipeline advances unless a finished word is held
    assign en    = !out_valid_reg || !out_stall;
    assign q_pop = en && !q_empty;

    for (genvar g = 0; g < NDIV; g++)
    begin : g_div
        rri_div u_div
        (
            .clk (clk),
            .en  (en),
            .num (q_dout.num[g]),
            .den (q_dout.den[g]),
            .quo (div_q[g])
        );
    end

    // Carry ray data alongside the dividers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < DIV_LAT; s++)
            begin
                vld_reg[s] <= 1'b0;
            end
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= !q_empty;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                vld_reg[s] <= vld_reg[s-1];
            end
            p_vld_reg     <= vld_reg[DIV_LAT-1];
            out_valid_reg <= p_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= q_dout.side;
            for (int s = 1; s < DIV_LAT; s++)
            begin
                side_reg[s] <= side_reg[s-1];
            end
            // Register quotients and plane products
            p_side_reg <= side_reg[DIV_LAT-1];
            for (int k = 0; k < NDIV; k++)
            begin
                p_q_reg[k] <= div_q[k];
            end
            prod_x_reg <= side_reg[DIV_LAT-1].dx * div_q[0];
            prod_y_reg <= side_reg[DIV_LAT-1].dy * div_q[0];
            if (p_vld_reg)
            begin
                hit_reg     <= hit_next;
                t_enter_reg <= te_next;
                t_exit_reg  <= tx_next;
            end
        end
    end

    // Decide the hit and the t values
    always_comb
    begin
        px = 65'(p_side_reg.ox) + 65'(prod_x_reg >>> FRAC_BITS);
        py = 65'(p_side_reg.oy) + 65'(prod_y_reg >>> FRAC_BITS);
        lx = p_side_reg.x_zero ? T_MIN : p_q_reg[0];
        hx = p_side_reg.x_zero ? T_MAX : p_q_reg[1];
        ly = p_side_reg.y_zero ? T_MIN : p_q_reg[2];
        hy = p_side_reg.y_zero ? T_MAX : p_q_reg[3];
        te_next  = p_q_reg[0];
        tx_next  = p_q_reg[0];
        hit_next = 1'b0;
        unique case (p_side_reg.mode)
            MODE_PLANE:
            begin
                hit_next = (65'(rect.min_x) <= px) && (px <= 65'(rect.max_x)) &&
                           (65'(rect.min_y) <= py) && (py <= 65'(rect.max_y));
            end
            MODE_MISS:
            begin
                hit_next = 1'b0;
            end
            MODE_SLAB:
            begin
                hit_next = (!p_side_reg.x_zero || p_side_reg.x_in) &&
                           (!p_side_reg.y_zero || p_side_reg.y_in) &&
                           !(lx > hy) && !(ly > hx);
                te_next  = (ly > lx) ? ly : lx;
                tx_next  = (hy < hx) ? hy : hx;
            end
            default:
            begin
                hit_next = 1'b0;
            end
        endcase
        // Drop hits wholly behind the origin, clamp entry at zero
        if (hit_next && te_next[31] && tx_next[31])
        begin
            hit_next = 1'b0;
        end
        if (!hit_next)
        begin
            te_next = NEG_ONE;
            tx_next = NEG_ONE;
        end
        else if (te_next[31] || (te_next == 32'sd0))
        begin
            te_next = 32'sd0;
        end
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign t_enter   = t_enter_reg;
    assign t_exit    = t_exit_reg;

endmodule

[src/rri_checker.sv]
// Port-level checks for the intersection block, bound to the top level.
`timescale 1ns / 1ps

module rri_checker import rri_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               out_valid,
    input logic               out_stall,
    input logic               hit,
    input logic signed [31:0] t_enter,
    input logic signed [31:0] t_exit
);

    // Hold a stalled output word
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(hit) && $stable(t_enter) && $stable(t_exit))
        else $error("output word changed while stalled");

    // Misses report -1.0 on both t values
    a_miss_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> (t_enter == NEG_ONE) && (t_exit == NEG_ONE))
        else $error("miss without -1.0 t values");

    // Hits carry an entry clamped at zero; inverted bounds can still leave a negative exit
    a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit |-> !t_enter[31])
        else $error("hit with negative entry t value");

endmodule

bind ray_rectangle_intersect_top rri_checker u_chk
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .hit       (hit),
    .t_enter   (t_enter),
    .t_exit    (t_exit)
);
